// ===== src/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and codes for the LRU buffer cache.
// ----------------------------------------------------------------------------
package bbc_pkg;

  typedef enum logic [1:0] {
    REQ_GET     = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_PIN     = 2'd2,
    REQ_UNPIN   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_UNDER  = 2'd2,
    ST_SAT    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SCAN = 2'd1,
    BK_DONE = 2'd2
  } bk_state_t;

  localparam logic [7:0] REFS_MAX = 8'd255;

  // Request word as it travels from the front to the back.
  typedef struct packed {
    req_t        op;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [7:0]  slot;   // zero-extended buffer slot
    logic [31:0] now;
    logic        in_range;
  } cmd_t;

endpackage

// ===== src/bbc_front.sv =====
// ----------------------------------------------------------------------------
// bbc_front
// Accepts requests, classifies slot range, queues them for the back end.
// ----------------------------------------------------------------------------
module bbc_front #(
  parameter int NUM_BUFFERS = 32,
  parameter int QDEPTH      = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    req_type,
  input  logic [7:0]    device_id,
  input  logic [31:0]   block_number,
  input  logic [4:0]    buffer_slot,
  input  logic [31:0]   now_tick,
  output logic          q_valid,
  input  logic          q_ready,
  output bbc_pkg::cmd_t q_cmd
);
  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  bbc_pkg::cmd_t  q [QDEPTH];
  logic [AW-1:0]  wp, rp;
  logic [AW:0]    cnt;
  logic           push, pop;
  bbc_pkg::cmd_t  cmd_in;

  // classify the incoming word
  always_comb begin
    cmd_in.op       = bbc_pkg::req_t'(req_type);
    cmd_in.dev      = device_id;
    cmd_in.blk      = block_number;
    cmd_in.slot     = {3'd0, buffer_slot};
    cmd_in.now      = now_tick;
    cmd_in.in_range = ({3'd0, buffer_slot} < 8'(NUM_BUFFERS)) || (NUM_BUFFERS > 31);
  end

  assign in_ready = (cnt != (AW+1)'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != '0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = q[rp];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q[wp] <= cmd_in;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(QDEPTH-1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(QDEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ===== src/bbc_back.sv =====
// ----------------------------------------------------------------------------
// bbc_back
// Executes requests against the entry table; get scans one entry a cycle.
// ----------------------------------------------------------------------------
module bbc_back #(
  parameter int NUM_BUFFERS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  bbc_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [4:0]    slot_out,
  output logic          was_hit,
  output logic          fill_needed,
  output logic [1:0]    status
);
  localparam int IW = $clog2(NUM_BUFFERS);

  logic [7:0]  e_dev  [NUM_BUFFERS];
  logic [31:0] e_blk  [NUM_BUFFERS];
  logic [7:0]  e_refs [NUM_BUFFERS];
  logic [31:0] e_last [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] e_valid;

  bbc_pkg::bk_state_t state, state_next;
  bbc_pkg::cmd_t cmd;
  logic [IW:0]   idx;
  logic          hit_f, vic_f;
  logic [IW-1:0] hit_i, vic_i;
  logic [31:0]   vic_t;
  logic [IW-1:0] ci, si;
  logic          cur_match, cur_free, take;
  logic          scan_end;

  assign q_ready  = (state == bbc_pkg::BK_IDLE);
  assign take     = q_valid && q_ready;
  assign ci       = idx[IW-1:0];
  assign si       = cmd.slot[IW-1:0];
  assign cur_match = e_valid[ci] && e_dev[ci] == cmd.dev && e_blk[ci] == cmd.blk;
  assign cur_free  = (e_refs[ci] == 8'd0);
  assign scan_end  = (idx == (IW+1)'(NUM_BUFFERS));

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      bbc_pkg::BK_IDLE: if (take) state_next = bbc_pkg::BK_SCAN;
      bbc_pkg::BK_SCAN: begin
        if (cmd.op != bbc_pkg::REQ_GET || scan_end) state_next = bbc_pkg::BK_DONE;
      end
      bbc_pkg::BK_DONE: if (out_ready) state_next = bbc_pkg::BK_IDLE;
      default: state_next = bbc_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bbc_pkg::BK_IDLE;
    else     state <= state_next;
  end

  assign out_valid = (state == bbc_pkg::BK_DONE);

  // datapath: scan, then update and form the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= '0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        e_dev[i] <= '0; e_blk[i] <= '0; e_refs[i] <= '0; e_last[i] <= '0;
      end
    end else begin
      case (state)
        bbc_pkg::BK_IDLE: if (take) begin
          cmd <= q_cmd; idx <= '0; hit_f <= 1'b0; vic_f <= 1'b0;
        end
        bbc_pkg::BK_SCAN: begin
          was_hit <= 1'b0; fill_needed <= 1'b0; status <= bbc_pkg::ST_OK;
          slot_out <= cmd.slot[4:0];
          if (cmd.op == bbc_pkg::REQ_GET) begin
            if (!scan_end) begin
              if (cur_match && !hit_f) begin hit_f <= 1'b1; hit_i <= ci; end
              if (cur_free && (!vic_f || e_last[ci] < vic_t)) begin
                vic_f <= 1'b1; vic_i <= ci; vic_t <= e_last[ci];
              end
              idx <= idx + 1'b1;
            end else if (hit_f) begin
              was_hit  <= 1'b1;
              slot_out <= 5'(hit_i);
              if (e_refs[hit_i] >= bbc_pkg::REFS_MAX) status <= bbc_pkg::ST_SAT;
              else e_refs[hit_i] <= e_refs[hit_i] + 8'd1;
            end else if (vic_f) begin
              slot_out <= 5'(vic_i); fill_needed <= 1'b1;
              e_dev[vic_i] <= cmd.dev; e_blk[vic_i] <= cmd.blk;
              e_refs[vic_i] <= 8'd1; e_valid[vic_i] <= 1'b1;
            end else begin
              slot_out <= '0; status <= bbc_pkg::ST_NOFREE;
            end
          end else if (cmd.in_range) begin
            if (cmd.op == bbc_pkg::REQ_PIN) begin
              if (e_refs[si] >= bbc_pkg::REFS_MAX) status <= bbc_pkg::ST_SAT;
              else e_refs[si] <= e_refs[si] + 8'd1;
            end else if (e_refs[si] == 8'd0) begin
              status <= bbc_pkg::ST_UNDER;
            end else begin
              e_refs[si] <= e_refs[si] - 8'd1;
              if (cmd.op == bbc_pkg::REQ_RELEASE && e_refs[si] == 8'd1)
                e_last[si] <= cmd.now;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== src/block_buffer_cache_lru.sv =====
// A get scans one entry a cycle through the scan sequencer; release, pin
// and unpin skip the scan. The back end takes a new request only when idle,
// after the previous result has been taken (out_ready).
// A two-word queue lets requests arrive while the back end works.
// Reset (rst, synchronous): all entries cleared, queue empty.
// ----------------------------------------------------------------------------
// block_buffer_cache_lru
// LRU buffer cache with reference counts, front queue and scanning back end.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru #(
  parameter int NUM_BUFFERS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  device_id,
  input  logic [31:0] block_number,
  input  logic [4:0]  buffer_slot,
  input  logic [31:0] now_tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  slot_out,
  output logic        was_hit,
  output logic        fill_needed,
  output logic [1:0]  status
);
  logic          q_valid, q_ready;
  bbc_pkg::cmd_t q_cmd;

  bbc_front #(.NUM_BUFFERS(NUM_BUFFERS), .QDEPTH(2)) u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .device_id, .block_number,
    .buffer_slot, .now_tick, .q_valid, .q_ready, .q_cmd
  );

  bbc_back #(.NUM_BUFFERS(NUM_BUFFERS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .out_valid, .out_ready,
    .slot_out, .was_hit, .fill_needed, .status
  );

`ifndef SYNTHESIS
  a_hit_no_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(was_hit && fill_needed)) else $error("hit with fill");
  a_nofree_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == bbc_pkg::ST_NOFREE) |-> (slot_out == 5'd0 && !was_hit))
    else $error("bad no-free result");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(slot_out) && $stable(status)))
    else $error("result dropped");
`endif
endmodule

// ===== bench/block_buffer_cache_lru_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_tb
// Drives get, release, pin and unpin words into the buffer cache, predicts
// each response from a local copy of the entry table and checks every field.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_tb;

  localparam int NBUF       = 32;
  localparam int HANG_LIMIT = 20000;

  typedef struct packed {
    logic [4:0]        slot;
    logic              hit;
    logic              fill;
    bbc_pkg::status_t  st;
  } resp_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic [7:0]  device_id;
  logic [31:0] block_number;
  logic [4:0]  buffer_slot;
  logic [31:0] now_tick;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  slot_out;
  logic        was_hit;
  logic        fill_needed;
  logic [1:0]  status;

  // local copy of the entry table
  logic [7:0]  tag_dev  [NBUF];
  logic [31:0] tag_blk  [NBUF];
  logic [7:0]  ref_cnt  [NBUF];
  logic [31:0] last_use [NBUF];
  logic        present  [NBUF];

  resp_t resp_q[$];
  int    fail_cnt;
  int    idle_cnt;
  bit    no_gaps;

  // tags already handed out, reused for hits
  logic [7:0]  seen_dev[$];
  logic [31:0] seen_blk[$];

  block_buffer_cache_lru #(.NUM_BUFFERS(NBUF)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .device_id    (device_id),
    .block_number (block_number),
    .buffer_slot  (buffer_slot),
    .now_tick     (now_tick),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .slot_out     (slot_out),
    .was_hit      (was_hit),
    .fill_needed  (fill_needed),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Update the table for one word and return the response it should give.
  function automatic resp_t cache_step(bbc_pkg::req_t op, logic [7:0] dev,
                                       logic [31:0] blk, logic [4:0] slot,
                                       logic [31:0] now);
    resp_t r;
    int    victim;
    r = '{slot: slot, hit: 1'b0, fill: 1'b0, st: bbc_pkg::ST_OK};
    if (op == bbc_pkg::REQ_GET) begin
      for (int i = 0; i < NBUF; i++) begin
        if (present[i] && tag_dev[i] == dev && tag_blk[i] == blk) begin
          r.slot = i[4:0];
          r.hit  = 1'b1;
          if (ref_cnt[i] == bbc_pkg::REFS_MAX) r.st = bbc_pkg::ST_SAT;
          else ref_cnt[i]++;
          return r;
        end
      end
      victim = -1;
      for (int i = 0; i < NBUF; i++)
        if (ref_cnt[i] == 0 && (victim < 0 || last_use[i] < last_use[victim]))
          victim = i;
      if (victim < 0) begin
        r.slot = '0;
        r.st   = bbc_pkg::ST_NOFREE;
        return r;
      end
      tag_dev[victim] = dev;
      tag_blk[victim] = blk;
      ref_cnt[victim] = 8'd1;
      present[victim] = 1'b1;
      r.slot = victim[4:0];
      r.fill = 1'b1;
      return r;
    end
    if (slot >= NBUF) return r;
    if (op == bbc_pkg::REQ_PIN) begin
      if (ref_cnt[slot] == bbc_pkg::REFS_MAX) r.st = bbc_pkg::ST_SAT;
      else ref_cnt[slot]++;
      return r;
    end
    if (ref_cnt[slot] == 0) begin
      r.st = bbc_pkg::ST_UNDER;
      return r;
    end
    ref_cnt[slot]--;
    if (op == bbc_pkg::REQ_RELEASE && ref_cnt[slot] == 0) last_use[slot] = now;
    return r;
  endfunction

  // Send one word; the expectation is queued at the accepting edge.
  task automatic send_word(bbc_pkg::req_t op, logic [7:0] dev, logic [31:0] blk,
                           logic [4:0] slot, logic [31:0] now);
    while (!no_gaps && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= op;
    device_id    <= dev;
    block_number <= blk;
    buffer_slot  <= slot;
    now_tick     <= now;
    do @(posedge clk); while (!in_ready);
    resp_q.push_back(cache_step(op, dev, blk, slot, now));
    if (op == bbc_pkg::REQ_GET) begin
      seen_dev.push_back(dev);
      seen_blk.push_back(blk);
    end
  endtask

  task automatic get_word(logic [7:0] dev, logic [31:0] blk);
    send_word(bbc_pkg::REQ_GET, dev, blk, 5'd0, 32'd0);
  endtask

  // Directed corners: tags at extremes, hit, underflow, highest slot.
  task automatic test_directed();
    get_word(8'h00, 32'h0000_0000);
    get_word(8'hFF, 32'hFFFF_FFFF);
    get_word(8'h00, 32'h0000_0000);
    send_word(bbc_pkg::REQ_RELEASE, 8'h00, 32'h0, 5'd0, 32'hFFFF_FFFF);
    send_word(bbc_pkg::REQ_RELEASE, 8'h00, 32'h0, 5'd0, 32'h0000_0005);
    send_word(bbc_pkg::REQ_RELEASE, 8'h00, 32'h0, 5'd0, 32'h0);
    send_word(bbc_pkg::REQ_UNPIN, 8'h00, 32'h0, 5'd31, 32'h0);
    send_word(bbc_pkg::REQ_PIN, 8'h00, 32'h0, 5'd1, 32'h0);
    send_word(bbc_pkg::REQ_UNPIN, 8'h00, 32'h0, 5'd1, 32'h0);
    send_word(bbc_pkg::REQ_PIN, 8'hA5, 32'h5A5A_5A5A, 5'd31, 32'hFFFF_FFFF);
    get_word(8'h12, 32'h8000_0001);
    get_word(8'hFF, 32'hFFFF_FFFF);
  endtask

  // Fill every entry so the next miss finds no free buffer, then free all.
  task automatic test_no_free();
    for (int i = 0; i < NBUF + 2; i++) get_word(8'h40, 32'h1000 + i);
    for (int i = 0; i < NBUF; i++)
      while (ref_cnt[i] != 0)
        send_word(bbc_pkg::REQ_RELEASE, 8'h0, 32'h0, i[4:0], $urandom);
  endtask

  // Drive a count up to its ceiling, check pin and hit saturation, then back down.
  task automatic test_saturate();
    logic [4:0] s;
    get_word(8'h77, 32'hCAFE_0000);
    s = resp_q[$].slot;
    for (int i = 0; i < 256; i++) send_word(bbc_pkg::REQ_PIN, 8'h0, 32'h0, s, 32'h0);
    get_word(8'h77, 32'hCAFE_0000);
    for (int i = 0; i < 256; i++)
      send_word(bbc_pkg::REQ_RELEASE, 8'h0, 32'h0, s, $urandom);
  endtask

  // Random mix biased toward reuse of known tags, so hits and LRU picks occur.
  task automatic test_random(int n);
    int            k;
    bbc_pkg::req_t op;
    logic [7:0]    dev;
    logic [31:0]   blk;
    logic [4:0]    slot;
    logic [31:0]   now;
    for (int i = 0; i < n; i++) begin
      no_gaps = (i >= n / 2 && i < n / 2 + 150);
      op  = bbc_pkg::req_t'(2'($urandom_range(3)));
      if ($urandom_range(99) < 40) op = bbc_pkg::REQ_GET;
      dev = 8'($urandom);
      blk = $urandom;
      if (op == bbc_pkg::REQ_GET && seen_dev.size() > 0 && $urandom_range(1)) begin
        k   = $urandom_range(seen_dev.size() - 1);
        dev = seen_dev[k];
        blk = seen_blk[k];
      end else if ($urandom_range(3) == 0) begin
        dev = 8'($urandom_range(3));
        blk = $urandom_range(7);
      end
      slot = 5'($urandom);
      now  = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom;
      send_word(op, dev, blk, slot, now);
    end
    no_gaps = 1'b0;
  endtask

  // Response checker with random back-pressure.
  always @(posedge clk) begin
    resp_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (resp_q.size() == 0) begin
          $error("response with none expected: slot %0d", slot_out);
          fail_cnt++;
        end else begin
          e = resp_q.pop_front();
          if (slot_out !== e.slot) begin
            $error("slot_out expected %0d actual %0d", e.slot, slot_out); fail_cnt++;
          end
          if (was_hit !== e.hit) begin
            $error("was_hit expected %0d actual %0d", e.hit, was_hit); fail_cnt++;
          end
          if (fill_needed !== e.fill) begin
            $error("fill_needed expected %0d actual %0d", e.fill, fill_needed); fail_cnt++;
          end
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status); fail_cnt++;
          end
        end
      end
      out_ready <= no_gaps || ($urandom_range(99) >= 35);
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= HANG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    fail_cnt     = 0;
    idle_cnt     = 0;
    no_gaps      = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = '0;
    device_id    = '0;
    block_number = '0;
    buffer_slot  = '0;
    now_tick     = '0;
    for (int i = 0; i < NBUF; i++) begin
      tag_dev[i] = '0; tag_blk[i] = '0; ref_cnt[i] = '0;
      last_use[i] = '0; present[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_no_free();
    test_saturate();
    test_random(700);
    in_valid <= 1'b0;
    wait (resp_q.size() == 0);
    repeat (4 * NBUF) @(posedge clk);
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
